>>> rtl/core/md5_pkg.sv
package md5_pkg;

  localparam logic [31:0] Iv0 = 32'h67452301;
  localparam logic [31:0] Iv1 = 32'hefcdab89;
  localparam logic [31:0] Iv2 = 32'h98badcfe;
  localparam logic [31:0] Iv3 = 32'h10325476;

  localparam logic [7:0] PadByte = 8'h80;

  localparam logic [31:0] RoundK [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam logic [4:0] RoundS [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
  };

  // block buffer write request: one 32-bit word, per-byte enables
  typedef struct packed {
    logic        en;
    logic [3:0]  addr;
    logic [3:0]  be;
    logic [31:0] data;
  } wr_req_t;

  // message word used by round r
  function automatic logic [3:0] msg_index(input logic [5:0] r);
    logic [3:0] lo;
    logic [3:0] g;
    lo = r[3:0];
    case (r[5:4])
      2'd0:    g = lo;
      2'd1:    g = 4'((lo << 2) + lo + 4'd1);
      2'd2:    g = 4'((lo << 1) + lo + 4'd5);
      default: g = 4'((lo << 3) - lo);
    endcase
    return g;
  endfunction

endpackage

>>> rtl/core/md5_hash_engine.sv
// MD5 hash engine, one message byte per request.
// Input channel: in_tdata carries the byte, in_tuser selects absorb (0) or
// finish (1). in_tready is high only while the engine is idle.
// An absorb request writes its byte into the block buffer. The 64th byte of a
// block starts a compression: a read-ahead step, 64 rounds through the single
// round unit (one round per cycle) and a fold step; in_tready stays low
// throughout. A finish request pads the block word by word, starting at the
// word that holds the next free byte, runs one compression, or two when 56
// or more bytes were buffered (a second pad pass over all 16 words
// and a second compression), then presents the digest on the output
// channel: four requests, word 0 first, out_tuser the word index, out_tlast
// on word 3. Each word stays on out_tdata until the receiver takes it; a
// stall simply holds the engine in its output phase. After the fourth word
// the chaining words return to the initial values and the engine goes idle.
// Reset (rst_n low, synchronous) loads the initial chaining words and clears
// the byte counts; the block buffer is not cleared.
module md5_hash_engine (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] digest_word
  output logic [1:0]  out_tuser,  // [1:0] word_index
  output logic        out_tlast   // last_word
);
  import md5_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_PAD, ST_PREP, ST_RUN, ST_FOLD, ST_OUT
  } state_t;

  state_t      state_r, state_nxt;
  logic [31:0] chain_r [4];
  logic [31:0] chain_nxt [4];
  logic [5:0]  fill_r, fill_nxt;      // bytes buffered in the block
  logic [60:0] msg_r, msg_nxt;        // message bytes, mod 2^61
  logic        fin_r, fin_nxt;        // finishing the message
  logic        len_pass_r, len_pass_nxt; // this pad pass writes the length
  logic        mark_r, mark_nxt;      // this pad pass writes the 0x80 byte
  logic [3:0]  ptr_r, ptr_nxt;        // pad word pointer
  logic [5:0]  rnd_r, rnd_nxt;
  logic [1:0]  idx_r, idx_nxt;

  logic [31:0] a_r, b_r, c_r, d_r;
  logic [31:0] a_nxt, b_nxt, c_nxt, d_nxt;
  logic [31:0] ra, rb, rc, rd;

  wr_req_t     wr_req;
  logic [3:0]  rd_addr;
  logic [31:0] w_data;
  logic [63:0] bit_len;
  logic        in_acc, out_acc;

  md5_blkbuf u_buf (
    .clk     (clk),
    .wr_req  (wr_req),
    .rd_addr (rd_addr),
    .rd_data (w_data)
  );

  md5_round u_round (
    .rnd   (rnd_r),
    .a_in  (a_r),
    .b_in  (b_r),
    .c_in  (c_r),
    .d_in  (d_r),
    .w_in  (w_data),
    .a_out (ra),
    .b_out (rb),
    .c_out (rc),
    .d_out (rd)
  );

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = (state_r == ST_OUT);
  assign out_acc    = out_tvalid && out_tready;
  assign out_tdata  = chain_r[idx_r];
  assign out_tuser  = idx_r;
  assign out_tlast  = (idx_r == 2'd3);

  assign bit_len = {msg_r, 3'b000};

  always_comb begin
    state_nxt    = state_r;
    chain_nxt    = chain_r;
    fill_nxt     = fill_r;
    msg_nxt      = msg_r;
    fin_nxt      = fin_r;
    len_pass_nxt = len_pass_r;
    mark_nxt     = mark_r;
    ptr_nxt      = ptr_r;
    rnd_nxt      = rnd_r;
    idx_nxt      = idx_r;
    a_nxt        = a_r;
    b_nxt        = b_r;
    c_nxt        = c_r;
    d_nxt        = d_r;
    wr_req       = '0;
    rd_addr      = 4'd0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (!in_tuser) begin
            // absorb: drop the byte into its lane
            wr_req.en   = 1'b1;
            wr_req.addr = fill_r[5:2];
            wr_req.be   = 4'(4'b0001 << fill_r[1:0]);
            wr_req.data = {4{in_tdata}};
            fill_nxt    = fill_r + 6'd1;
            if (fill_r == 6'd63) begin
              msg_nxt   = msg_r + 61'd64;
              fin_nxt   = 1'b0;
              state_nxt = ST_PREP;
            end
          end else begin
            msg_nxt      = msg_r + 61'(fill_r);
            fin_nxt      = 1'b1;
            mark_nxt     = 1'b1;
            len_pass_nxt = (fill_r[5:3] != 3'd7);
            ptr_nxt      = fill_r[5:2];
            state_nxt    = ST_PAD;
          end
        end
      end

      ST_PAD: begin
        wr_req.en   = 1'b1;
        wr_req.addr = ptr_r;
        wr_req.be   = 4'b1111;
        wr_req.data = 32'd0;
        if (mark_r && ptr_r == fill_r[5:2]) begin
          // keep buffered bytes below the pad marker
          wr_req.be   = 4'(4'b1111 << fill_r[1:0]);
          wr_req.data = {24'd0, PadByte} << {fill_r[1:0], 3'b000};
        end else if (len_pass_r && ptr_r == 4'd14) begin
          wr_req.data = bit_len[31:0];
        end else if (len_pass_r && ptr_r == 4'd15) begin
          wr_req.data = bit_len[63:32];
        end
        ptr_nxt = ptr_r + 4'd1;
        if (ptr_r == 4'd15) begin
          state_nxt = ST_PREP;
        end
      end

      ST_PREP: begin
        rd_addr   = msg_index(6'd0);
        a_nxt     = chain_r[0];
        b_nxt     = chain_r[1];
        c_nxt     = chain_r[2];
        d_nxt     = chain_r[3];
        rnd_nxt   = 6'd0;
        state_nxt = ST_RUN;
      end

      ST_RUN: begin
        // fetch next round's word while this round computes
        rd_addr = msg_index(rnd_r + 6'd1);
        a_nxt   = ra;
        b_nxt   = rb;
        c_nxt   = rc;
        d_nxt   = rd;
        rnd_nxt = rnd_r + 6'd1;
        if (rnd_r == 6'd63) begin
          state_nxt = ST_FOLD;
        end
      end

      ST_FOLD: begin
        chain_nxt[0] = chain_r[0] + a_r;
        chain_nxt[1] = chain_r[1] + b_r;
        chain_nxt[2] = chain_r[2] + c_r;
        chain_nxt[3] = chain_r[3] + d_r;
        if (!fin_r) begin
          state_nxt = ST_IDLE;
        end else if (!len_pass_r) begin
          // padding spilled over: one more block of zeros and length
          len_pass_nxt = 1'b1;
          mark_nxt     = 1'b0;
          ptr_nxt      = 4'd0;
          state_nxt    = ST_PAD;
        end else begin
          idx_nxt   = 2'd0;
          state_nxt = ST_OUT;
        end
      end

      ST_OUT: begin
        if (out_acc) begin
          idx_nxt = idx_r + 2'd1;
          if (idx_r == 2'd3) begin
            chain_nxt = '{Iv0, Iv1, Iv2, Iv3};
            fill_nxt  = 6'd0;
            msg_nxt   = 61'd0;
            fin_nxt   = 1'b0;
            state_nxt = ST_IDLE;
          end
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      chain_r    <= '{Iv0, Iv1, Iv2, Iv3};
      fill_r     <= 6'd0;
      msg_r      <= 61'd0;
      fin_r      <= 1'b0;
      len_pass_r <= 1'b0;
      mark_r     <= 1'b0;
      ptr_r      <= 4'd0;
      rnd_r      <= 6'd0;
      idx_r      <= 2'd0;
    end else begin
      state_r    <= state_nxt;
      chain_r    <= chain_nxt;
      fill_r     <= fill_nxt;
      msg_r      <= msg_nxt;
      fin_r      <= fin_nxt;
      len_pass_r <= len_pass_nxt;
      mark_r     <= mark_nxt;
      ptr_r      <= ptr_nxt;
      rnd_r      <= rnd_nxt;
      idx_r      <= idx_nxt;
    end
  end

  // round working registers
  always_ff @(posedge clk) begin
    a_r <= a_nxt;
    b_r <= b_nxt;
    c_r <= c_nxt;
    d_r <= d_nxt;
  end

endmodule

>>> rtl/core/md5_blkbuf.sv
module md5_blkbuf (
  input  logic             clk,
  input  md5_pkg::wr_req_t wr_req,
  input  logic [3:0]       rd_addr,
  output logic [31:0]      rd_data
);
  import md5_pkg::*;

  // 16 little-endian message words
  logic [31:0] mem [16];
  logic [31:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_req.en) begin
      for (int i = 0; i < 4; i++) begin
        if (wr_req.be[i]) begin
          mem[wr_req.addr][8*i +: 8] <= wr_req.data[8*i +: 8];
        end
      end
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/core/md5_round.sv
module md5_round (
  input  logic [5:0]  rnd,
  input  logic [31:0] a_in,
  input  logic [31:0] b_in,
  input  logic [31:0] c_in,
  input  logic [31:0] d_in,
  input  logic [31:0] w_in,
  output logic [31:0] a_out,
  output logic [31:0] b_out,
  output logic [31:0] c_out,
  output logic [31:0] d_out
);
  import md5_pkg::*;

  logic [31:0] f;
  logic [31:0] t;
  logic [4:0]  s;
  logic [63:0] rot;

  always_comb begin
    case (rnd[5:4])
      2'd0:    f = (b_in & c_in) | (~b_in & d_in);
      2'd1:    f = (d_in & b_in) | (~d_in & c_in);
      2'd2:    f = b_in ^ c_in ^ d_in;
      default: f = c_in ^ (b_in | ~d_in);
    endcase
  end

  assign t   = f + a_in + RoundK[rnd] + w_in;
  assign s   = RoundS[{rnd[5:4], rnd[1:0]}];
  assign rot = {t, t} << s;

  assign a_out = d_in;
  assign d_out = c_in;
  assign c_out = b_in;
  assign b_out = b_in + rot[63:32];

endmodule

>>> dv/tb_top.sv
module tb_top;

  // request kinds on in_tuser
  typedef enum logic {
    OP_ABSORB = 1'b0,
    OP_FINISH = 1'b1
  } md5_op_e;

  // one digest word as the output channel presents it
  typedef struct {
    logic [31:0] word;
    logic [1:0]  index;
    logic        last;
  } digest_word_t;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned StallBurst  = 300;   // long receiver hold-off
  localparam int unsigned SettleCycles = 20;   // quiet time after the last word

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        in_tuser = OP_ABSORB;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  md5_hash_engine i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Digest predictor: its own chaining words, block buffer and byte counts.
  // ---------------------------------------------------------------------------
  logic [31:0]  hash_state [4];
  logic [7:0]   block_buf [64];
  int unsigned  fill_len;
  logic [60:0]  done_bytes;        // bytes in completed blocks, wraps at 2^61

  digest_word_t pending_digest [$];

  int unsigned requests_sent;
  int unsigned messages_sent;
  int unsigned words_checked;
  int unsigned error_count;
  int unsigned cycle_count;

  // sender and receiver control; the test tasks set the idle percentages and the arm flag
  int unsigned recv_idle_pct = 0;
  int unsigned send_idle_pct = 0;
  logic        burst_arm = 1'b0;
  int unsigned burst_left = 0;

  function automatic void clear_hash_state();
    hash_state[0] = md5_pkg::Iv0;
    hash_state[1] = md5_pkg::Iv1;
    hash_state[2] = md5_pkg::Iv2;
    hash_state[3] = md5_pkg::Iv3;
    fill_len      = 0;
    done_bytes    = '0;
  endfunction

  // 64 rounds over block_buf, folded into hash_state
  function automatic void compress_block_buf();
    logic [31:0] msg_w [16];
    logic [31:0] a, b, c, d, f, t, rot;
    int unsigned g, s;
    for (int i = 0; i < 16; i++) begin
      msg_w[i] = {block_buf[4*i+3], block_buf[4*i+2], block_buf[4*i+1], block_buf[4*i]};
    end
    a = hash_state[0];
    b = hash_state[1];
    c = hash_state[2];
    d = hash_state[3];
    for (int r = 0; r < 64; r++) begin
      case (r / 16)
        0: begin
          f = (b & c) | (~b & d);
          g = r;
        end
        1: begin
          f = (d & b) | (~d & c);
          g = (5 * r + 1) % 16;
        end
        2: begin
          f = b ^ c ^ d;
          g = (3 * r + 5) % 16;
        end
        default: begin
          f = c ^ (b | ~d);
          g = (7 * r) % 16;
        end
      endcase
      t   = f + a + md5_pkg::RoundK[r] + msg_w[g];
      s   = md5_pkg::RoundS[(r / 16) * 4 + r % 4];
      rot = (t << s) | (t >> (32 - s));
      a   = d;
      d   = c;
      c   = b;
      b   = b + rot;
    end
    hash_state[0] += a;
    hash_state[1] += b;
    hash_state[2] += c;
    hash_state[3] += d;
  endfunction

  // update on one accepted request; a finish queues the four digest words
  function automatic void predict_digest(input md5_op_e op, input logic [7:0] data);
    logic [63:0]  bit_len;
    digest_word_t dw;
    if (op == OP_ABSORB) begin
      block_buf[fill_len] = data;
      fill_len++;
      if (fill_len == 64) begin
        compress_block_buf();
        done_bytes += 61'd64;
        fill_len = 0;
      end
      return;
    end
    done_bytes += 61'(fill_len);
    block_buf[fill_len] = md5_pkg::PadByte;
    for (int i = fill_len + 1; i < 64; i++) block_buf[i] = 8'h00;
    // no room for the length field: extra block
    if (fill_len >= 56) begin
      compress_block_buf();
      for (int i = 0; i < 64; i++) block_buf[i] = 8'h00;
    end
    bit_len = {done_bytes, 3'b000};
    for (int i = 0; i < 8; i++) block_buf[56 + i] = bit_len[8*i +: 8];
    compress_block_buf();
    for (int i = 0; i < 4; i++) begin
      dw.word  = hash_state[i];
      dw.index = 2'(i);
      dw.last  = (i == 3);
      pending_digest.push_back(dw);
    end
    clear_hash_state();
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver: random out_tready, or a long hold-off once armed.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (burst_arm) begin
      burst_arm  <= 1'b0;
      burst_left <= StallBurst;
      out_tready <= 1'b0;
    end else if (burst_left > 0) begin
      burst_left <= burst_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Result check: every taken word against the oldest predicted one.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_digest
    digest_word_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_digest.size() == 0) begin
        $display("%0t: unexpected digest word: expected none, got %h idx %0d last %0b",
                 $time, out_tdata, out_tuser, out_tlast);
        error_count++;
      end else begin
        want = pending_digest.pop_front();
        words_checked++;
        if (out_tdata !== want.word) begin
          $display("%0t: digest word mismatch: expected %h, got %h",
                   $time, want.word, out_tdata);
          error_count++;
        end
        if (out_tuser !== want.index) begin
          $display("%0t: word index mismatch: expected %0d, got %0d",
                   $time, want.index, out_tuser);
          error_count++;
        end
        if (out_tlast !== want.last) begin
          $display("%0t: last flag mismatch: expected %0b, got %0b",
                   $time, want.last, out_tlast);
          error_count++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("%0t: timeout, %0d digest words still pending", $time, pending_digest.size());
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------

  // Offer one request and hold it until taken. in_tvalid stays high into the
  // next request unless the random gap drops it.
  task automatic send_request(input md5_op_e op, input logic [7:0] data);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= data;
    do @(posedge clk); while (!in_tready);
    predict_digest(op, data);
    requests_sent++;
    if (op == OP_FINISH) messages_sent++;
  endtask

  // random bytes, then a finish carrying a random (ignored) data byte
  task automatic send_message(input int unsigned len);
    for (int i = 0; i < len; i++) send_request(OP_ABSORB, 8'($urandom_range(255)));
    send_request(OP_FINISH, 8'($urandom_range(255)));
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_digest.size() != 0) @(posedge clk);
  endtask

  // empty message, ignored data on finish, byte extremes, "abc"
  task automatic test_directed_vectors();
    send_idle_pct = 0;
    recv_idle_pct <= 0;
    send_request(OP_FINISH, 8'h00);
    send_request(OP_FINISH, 8'hff);
    send_request(OP_ABSORB, 8'h00);
    send_request(OP_FINISH, 8'h00);
    send_request(OP_ABSORB, 8'hff);
    send_request(OP_FINISH, 8'h55);
    send_request(OP_ABSORB, 8'h61);
    send_request(OP_ABSORB, 8'h62);
    send_request(OP_ABSORB, 8'h63);
    send_request(OP_FINISH, 8'h00);
    send_request(OP_ABSORB, 8'h80);
    send_request(OP_ABSORB, 8'h7f);
    send_request(OP_FINISH, 8'haa);
    wait_drained();
  endtask

  // One idle mix: a block-boundary message first (if any), then short
  // messages until the request budget is used.
  task automatic test_random_messages(input int unsigned snd_pct, input int unsigned rcv_pct,
                                      input int unsigned edge_len, input int unsigned budget);
    int unsigned start;
    start = requests_sent;
    send_idle_pct = snd_pct;
    recv_idle_pct <= rcv_pct;
    if (edge_len > 0) send_message(edge_len);
    while (requests_sent - start < budget) begin
      // mostly short bodies, now and then an empty one
      if ($urandom_range(7) == 0) send_message(0);
      else send_message($urandom_range(14, 1));
    end
    wait_drained();
  endtask

  // Receiver stops for a long stretch while the sender keeps offering:
  // the engine parks in its output phase and in_tready stays low.
  task automatic test_output_backpressure();
    send_idle_pct = 0;
    recv_idle_pct <= 0;
    burst_arm <= 1'b1;
    send_message(5);
    send_message(9);
    send_message(3);
    wait_drained();
  endtask

  initial begin
    clear_hash_state();
    for (int i = 0; i < 64; i++) block_buf[i] = 8'h00;
    requests_sent = 0;
    messages_sent = 0;
    words_checked = 0;
    error_count   = 0;
    cycle_count   = 0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_vectors();
    // 56 bytes forces the two-block finish, 64 a full block plus empty tail
    test_random_messages(28, 46, 56, 60);
    test_random_messages(46, 28, 64, 40);
    test_random_messages(0, 0, 0, 10);
    test_output_backpressure();

    repeat (SettleCycles) @(posedge clk);

    $display("Run covered %0d requests in %0d messages, %0d digest words checked;",
             requests_sent, messages_sent, words_checked);
    $display("empty and byte-extreme messages, 56- and 64-byte padding edges, idle mixes, long stall.");
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/md5_pkg.sv
rtl/core/md5_blkbuf.sv
rtl/core/md5_round.sv
rtl/core/md5_hash_engine.sv
dv/tb_top.sv
